>>> rtl/core/mrrs_pkg.sv
package mrrs_pkg;

  localparam int TIME_W = 32;
  localparam int TAG_W  = 16;
  localparam int NP_W   = 4;
  localparam int QNT_W  = 16;
  localparam int CFG_W  = 16;

  localparam int DEF_MAX_SLOTS    = 8;
  localparam int DEF_RUN_DEPTH    = 64;
  localparam int DEF_WAIT_DEPTH   = 64;
  localparam int DEF_FINISH_DEPTH = 16;

  localparam logic [NP_W-1:0]  NP_RESET  = 4'd1;
  localparam logic [QNT_W-1:0] QNT_RESET = 16'd4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // input kinds
  localparam logic [1:0] KIND_NEW  = 2'd0;
  localparam logic [1:0] KIND_FIN  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // result kinds
  localparam logic [2:0] RK_CYCLE  = 3'd0;
  localparam logic [2:0] RK_DONE   = 3'd1;
  localparam logic [2:0] RK_INTR   = 3'd2;
  localparam logic [2:0] RK_ADDED  = 3'd3;
  localparam logic [2:0] RK_DISP   = 3'd4;
  localparam logic [2:0] RK_REJECT = 3'd5;

  // configuration register indexes
  localparam logic CFG_NUM_PROC = 1'b0;
  localparam logic CFG_QUANTUM  = 1'b1;

endpackage

>>> rtl/core/mrrs_ram.sv
module mrrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/multiprocessor_round_robin_scheduler.sv
// channel | signals                                      | accepted when
// input   | in_valid, in_ready, kind, task_tag           | in_valid & in_ready
// output  | out_valid, out_ready, result_kind,           | out_valid & out_ready
//         |   task_tag_res, value, last                  |
// config  | cfg_we, cfg_index, cfg_data                  | cfg_we
//
// a new task or finish request is taken in IDLE; a tick checks the pending finish
// requests, advances the time of each active slot, runs the bit-serial remainder
// unit (32 steps) on each busy slot when the quantum is nonzero, moves waiting
// tasks to the run fifo, fills idle slots from it and emits its results
// rst is synchronous: config to defaults, slots idle, all fifos empty
// a stalled output holds the sequencer in each state that emits a result; no new
// item is taken until the tick's last result has gone into the output register
module multiprocessor_round_robin_scheduler
  import mrrs_pkg::*;
#(
  parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
  parameter int RUN_DEPTH    = DEF_RUN_DEPTH,
  parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH,
  parameter int FINISH_DEPTH = DEF_FINISH_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [TAG_W-1:0]  task_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        result_kind,
  output logic [TAG_W-1:0]  task_tag_res,
  output logic [TIME_W-1:0] value,
  output logic              last,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCW = $clog2(MAX_SLOTS + 1);
  localparam int RAW = $clog2(RUN_DEPTH);
  localparam int RCW = $clog2(RUN_DEPTH + 1);
  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int FAW = $clog2(FINISH_DEPTH);
  localparam int FCW = $clog2(FINISH_DEPTH + 1);
  localparam int RW  = TAG_W + TIME_W;

  typedef enum logic [3:0] {
    IDLE, T_CYC, F_RD, F_CHK, I_INC, I_DIV, I_END,
    A_RD, A_WR, D_CHK, D_LD, E_INT, E_ADD, E_DSP
  } state_t;

  state_t state;

  // configuration
  logic [NP_W-1:0]  num_proc;
  logic [QNT_W-1:0] quantum;

  // slot table, small enough for flops
  logic              slot_busy [MAX_SLOTS];
  logic [TAG_W-1:0]  slot_tag  [MAX_SLOTS];
  logic [TIME_W-1:0] slot_time [MAX_SLOTS];

  // fifo bookkeeping
  logic [RAW-1:0] run_head, run_tail;
  logic [RCW-1:0] run_cnt;
  logic [WAW-1:0] wait_head, wait_tail;
  logic [WCW-1:0] wait_cnt;
  logic [FCW-1:0] fin_cnt, fin_i, fin_j;

  logic [TIME_W-1:0] tick_no;

  // sequencer registers
  logic [SCW-1:0] s_cnt;
  logic [SCW-1:0] int_cnt, dsp_cnt;
  logic [RCW-1:0] add_cnt;

  // remainder unit
  logic [TIME_W-1:0] dvd;
  logic [QNT_W-1:0]  rem;
  logic [4:0]        div_step;

  // memory ports
  logic           wait_we, wait_re;
  logic [WAW-1:0] wait_waddr;
  logic [TAG_W-1:0] wait_rdata;
  logic           fin_we, fin_re;
  logic [FAW-1:0] fin_waddr;
  logic [TAG_W-1:0] fin_wdata, fin_rdata;
  logic           run_we, run_re;
  logic [RW-1:0]  run_wdata, run_rdata;

  logic [SCW-1:0] n_act;
  logic [SW-1:0]  ss;
  logic           out_free, in_fire, out_load;
  logic           hit;
  logic [SW-1:0]  hit_slot;
  logic [TIME_W-1:0] t_inc, hit_time_p1;
  logic [QNT_W:0] div_try;
  logic           last_slot;
  logic           wait_full, fin_full, run_full;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign ss        = s_cnt[SW-1:0];
  assign last_slot = (s_cnt + SCW'(1)) == n_act;
  assign wait_full = wait_cnt >= WCW'(WAIT_DEPTH);
  assign fin_full  = fin_cnt >= FCW'(FINISH_DEPTH);
  assign run_full  = run_cnt >= RCW'(RUN_DEPTH);

  // slot count out of range is clamped
  always_comb begin
    if (num_proc == '0) begin
      n_act = SCW'(1);
    end else if (int'(num_proc) > MAX_SLOTS) begin
      n_act = SCW'(MAX_SLOTS);
    end else begin
      n_act = SCW'(num_proc);
    end
  end

  // saturating time + 1 for the slot under the cursor
  assign t_inc = (slot_time[ss] == TIME_MAX) ? TIME_MAX : slot_time[ss] + 1'b1;

  // first active busy slot holding the requested tag
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if ((SCW'(s) < n_act) && slot_busy[s] && (slot_tag[s] == fin_rdata)) begin
        hit      = 1'b1;
        hit_slot = SW'(s);
      end
    end
  end

  assign hit_time_p1 = (slot_time[hit_slot] == TIME_MAX) ? TIME_MAX
                                                         : slot_time[hit_slot] + 1'b1;

  // one restoring step of time % quantum
  assign div_try = {rem, dvd[TIME_W-1]};

  // a result enters the output register this cycle
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      IDLE:  out_load = in_fire && (((kind == KIND_NEW) && wait_full) ||
                                    ((kind == KIND_FIN) && fin_full));
      T_CYC: out_load = out_free;
      F_CHK: out_load = hit && out_free;
      E_INT, E_ADD, E_DSP: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  // memory control
  always_comb begin
    wait_we    = (state == IDLE) && in_fire && (kind == KIND_NEW) && !wait_full;
    wait_waddr = wait_tail;
    wait_re    = (state == A_RD);

    fin_we    = 1'b0;
    fin_waddr = fin_cnt[FAW-1:0];
    fin_wdata = task_tag;
    if ((state == IDLE) && in_fire && (kind == KIND_FIN) && !fin_full) begin
      fin_we = 1'b1;
    end else if ((state == F_CHK) && !hit) begin
      // unmatched request compacts down, keeping its order
      fin_we    = 1'b1;
      fin_waddr = fin_j[FAW-1:0];
      fin_wdata = fin_rdata;
    end
    fin_re = (state == F_RD);

    run_we    = ((state == I_END) && (rem == '0)) || (state == A_WR);
    run_wdata = (state == A_WR) ? {wait_rdata, TIME_W'(0)} : {slot_tag[ss], slot_time[ss]};
    run_re    = (state == D_CHK) && !slot_busy[ss] && (run_cnt != '0);
  end

  mrrs_ram #(.WIDTH(TAG_W), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata (task_tag),
    .re    (wait_re),
    .raddr (wait_head),
    .rdata (wait_rdata)
  );

  mrrs_ram #(.WIDTH(TAG_W), .DEPTH(FINISH_DEPTH)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (fin_waddr),
    .wdata (fin_wdata),
    .re    (fin_re),
    .raddr (fin_i[FAW-1:0]),
    .rdata (fin_rdata)
  );

  mrrs_ram #(.WIDTH(RW), .DEPTH(RUN_DEPTH)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_tail),
    .wdata (run_wdata),
    .re    (run_re),
    .raddr (run_head),
    .rdata (run_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      num_proc  <= NP_RESET;
      quantum   <= QNT_RESET;
      run_head  <= '0;
      run_tail  <= '0;
      run_cnt   <= '0;
      wait_head <= '0;
      wait_tail <= '0;
      wait_cnt  <= '0;
      fin_cnt   <= '0;
      fin_i     <= '0;
      fin_j     <= '0;
      tick_no   <= '0;
      s_cnt     <= '0;
      int_cnt   <= '0;
      add_cnt   <= '0;
      dsp_cnt   <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        slot_busy[s] <= 1'b0;
        slot_tag[s]  <= '0;
        slot_time[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_PROC: num_proc <= cfg_data[NP_W-1:0];
          CFG_QUANTUM:  quantum  <= cfg_data[QNT_W-1:0];
          default:      ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_fire) begin
            priority if (kind == KIND_NEW) begin
              if (wait_full) begin
                result_kind  <= RK_REJECT;
                task_tag_res <= task_tag;
                value        <= '0;
                last         <= 1'b1;
              end else begin
                wait_tail <= (wait_tail == WAW'(WAIT_DEPTH - 1)) ? '0 : wait_tail + 1'b1;
                wait_cnt  <= wait_cnt + 1'b1;
              end
            end else if (kind == KIND_FIN) begin
              if (fin_full) begin
                result_kind  <= RK_REJECT;
                task_tag_res <= task_tag;
                value        <= '0;
                last         <= 1'b1;
              end else begin
                fin_cnt <= fin_cnt + 1'b1;
              end
            end else if (kind == KIND_TICK) begin
              int_cnt <= '0;
              add_cnt <= '0;
              dsp_cnt <= '0;
              state   <= T_CYC;
            end else begin
              // unused kind: dropped
            end
          end
        end

        T_CYC: begin
          if (out_free) begin
            result_kind  <= RK_CYCLE;
            task_tag_res <= '0;
            value        <= tick_no;
            last         <= 1'b0;
            tick_no      <= tick_no + 1'b1;
            fin_i        <= '0;
            fin_j        <= '0;
            s_cnt        <= '0;
            state        <= (fin_cnt == '0) ? I_INC : F_RD;
          end
        end

        F_RD: state <= F_CHK;

        F_CHK: begin
          if (!hit || out_free) begin
            if (hit) begin
              result_kind            <= RK_DONE;
              task_tag_res           <= fin_rdata;
              value                  <= hit_time_p1;
              last                   <= 1'b0;
              slot_busy[hit_slot]    <= 1'b0;
              slot_tag[hit_slot]     <= '0;
              slot_time[hit_slot]    <= '0;
            end else begin
              fin_j <= fin_j + 1'b1;
            end
            if ((fin_i + 1'b1) == fin_cnt) begin
              fin_cnt <= hit ? fin_j : fin_j + 1'b1;
              state   <= I_INC;
            end else begin
              fin_i <= fin_i + 1'b1;
              state <= F_RD;
            end
          end
        end

        I_INC: begin
          slot_time[ss] <= t_inc;
          if (slot_busy[ss] && (quantum != '0) && !run_full) begin
            dvd      <= t_inc;
            rem      <= '0;
            div_step <= '0;
            state    <= I_DIV;
          end else if (last_slot) begin
            state <= (wait_cnt != '0 && !run_full) ? A_RD : D_CHK;
            s_cnt <= '0;
          end else begin
            s_cnt <= s_cnt + 1'b1;
          end
        end

        I_DIV: begin
          dvd <= {dvd[TIME_W-2:0], 1'b0};
          if (div_try >= {1'b0, quantum}) begin
            rem <= QNT_W'(div_try - {1'b0, quantum});
          end else begin
            rem <= div_try[QNT_W-1:0];
          end
          div_step <= div_step + 1'b1;
          if (div_step == 5'(TIME_W - 1)) begin
            state <= I_END;
          end
        end

        I_END: begin
          if (rem == '0) begin
            // preempt to the run fifo with its time
            run_tail      <= (run_tail == RAW'(RUN_DEPTH - 1)) ? '0 : run_tail + 1'b1;
            run_cnt       <= run_cnt + 1'b1;
            int_cnt       <= int_cnt + 1'b1;
            slot_busy[ss] <= 1'b0;
            slot_tag[ss]  <= '0;
            slot_time[ss] <= '0;
          end
          if (last_slot) begin
            state <= (wait_cnt != '0 && !(run_full || (rem == '0 &&
                      run_cnt == RCW'(RUN_DEPTH - 1)))) ? A_RD : D_CHK;
            s_cnt <= '0;
          end else begin
            s_cnt <= s_cnt + 1'b1;
            state <= I_INC;
          end
        end

        A_RD: state <= A_WR;

        A_WR: begin
          run_tail  <= (run_tail == RAW'(RUN_DEPTH - 1)) ? '0 : run_tail + 1'b1;
          run_cnt   <= run_cnt + 1'b1;
          wait_head <= (wait_head == WAW'(WAIT_DEPTH - 1)) ? '0 : wait_head + 1'b1;
          wait_cnt  <= wait_cnt - 1'b1;
          add_cnt   <= add_cnt + 1'b1;
          if ((wait_cnt != WCW'(1)) && (run_cnt != RCW'(RUN_DEPTH - 1))) begin
            state <= A_RD;
          end else begin
            s_cnt <= '0;
            state <= D_CHK;
          end
        end

        D_CHK: begin
          if (run_re) begin
            state <= D_LD;
          end else if (last_slot) begin
            state <= E_INT;
          end else begin
            s_cnt <= s_cnt + 1'b1;
          end
        end

        D_LD: begin
          slot_busy[ss] <= 1'b1;
          slot_tag[ss]  <= run_rdata[RW-1:TIME_W];
          slot_time[ss] <= run_rdata[TIME_W-1:0];
          run_head      <= (run_head == RAW'(RUN_DEPTH - 1)) ? '0 : run_head + 1'b1;
          run_cnt       <= run_cnt - 1'b1;
          dsp_cnt       <= dsp_cnt + 1'b1;
          if (last_slot) begin
            state <= E_INT;
          end else begin
            s_cnt <= s_cnt + 1'b1;
            state <= D_CHK;
          end
        end

        E_INT: begin
          if (out_free) begin
            result_kind  <= RK_INTR;
            task_tag_res <= '0;
            value        <= TIME_W'(int_cnt);
            last         <= 1'b0;
            state        <= E_ADD;
          end
        end

        E_ADD: begin
          if (out_free) begin
            result_kind  <= RK_ADDED;
            task_tag_res <= '0;
            value        <= TIME_W'(add_cnt);
            last         <= 1'b0;
            state        <= E_DSP;
          end
        end

        E_DSP: begin
          if (out_free) begin
            result_kind  <= RK_DISP;
            task_tag_res <= '0;
            value        <= TIME_W'(dsp_cnt);
            last         <= 1'b1;
            state        <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/mrrs_checker.sv
module mrrs_checker
  import mrrs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        result_kind,
  input logic [TAG_W-1:0]  task_tag_res,
  input logic [TIME_W-1:0] value,
  input logic              last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
    $stable(value) && $stable(task_tag_res) && $stable(last))
    else $error("result changed while stalled");

  // a reject is always the only result of its item
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RK_REJECT |-> last)
    else $error("reject without last");

  // only a dispatch count or a reject closes an item
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (result_kind == RK_DISP || result_kind == RK_REJECT))
    else $error("last on wrong result kind");

  // a tick keeps the input closed while it runs
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_TICK |=> !in_ready)
    else $error("input open during tick");

endmodule

bind multiprocessor_round_robin_scheduler mrrs_checker u_mrrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .kind         (kind),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .task_tag_res (task_tag_res),
  .value        (value),
  .last         (last)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mrrs_pkg::*;

  localparam int SLOTS = DEF_MAX_SLOTS;
  localparam int RUN_D = DEF_RUN_DEPTH;
  localparam int WAIT_D = DEF_WAIT_DEPTH;
  localparam int FIN_D = DEF_FINISH_DEPTH;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]        rkind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] val;
    logic              lst;
  } sched_result_t;

  // scheduler predictor and queue of expected results
  class sched_scoreboard;
    logic [NP_W-1:0]   np_reg;
    logic [QNT_W-1:0]  qnt_reg;
    bit                busy [SLOTS];
    logic [TAG_W-1:0]  stag [SLOTS];
    logic [TIME_W-1:0] stime [SLOTS];
    logic [TAG_W-1:0]  run_tag_q [$];
    logic [TIME_W-1:0] run_time_q [$];
    logic [TAG_W-1:0]  wait_q [$];
    logic [TAG_W-1:0]  fin_q [$];
    logic [TIME_W-1:0] tick_cnt;
    sched_result_t     pending_q [$];
    int                errors;

    function void clear();
      np_reg = NP_RESET;
      qnt_reg = QNT_RESET;
      foreach (busy[s]) begin
        busy[s] = 0;
        stag[s] = '0;
        stime[s] = '0;
      end
      run_tag_q.delete();
      run_time_q.delete();
      wait_q.delete();
      fin_q.delete();
      pending_q.delete();
      tick_cnt = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] d);
      if (idx == CFG_NUM_PROC) np_reg = d[NP_W-1:0];
      else qnt_reg = d[QNT_W-1:0];
    endfunction

    function void push_res(logic [2:0] rk, logic [TAG_W-1:0] t, logic [TIME_W-1:0] v,
                           logic l);
      sched_result_t r;
      r.rkind = rk;
      r.tag = t;
      r.val = v;
      r.lst = l;
      pending_q.push_back(r);
    endfunction

    function void note_item(logic [1:0] k, logic [TAG_W-1:0] t);
      int n;
      logic [TAG_W-1:0] keep [$];
      logic [TIME_W-1:0] intr, addc, disp;
      bit hit;
      if (k == KIND_NEW) begin
        if (wait_q.size() >= WAIT_D) push_res(RK_REJECT, t, '0, 1);
        else wait_q.push_back(t);
        return;
      end
      if (k == KIND_FIN) begin
        if (fin_q.size() >= FIN_D) push_res(RK_REJECT, t, '0, 1);
        else fin_q.push_back(t);
        return;
      end
      if (k != KIND_TICK) return;
      n = (np_reg == 0) ? 1 : (np_reg > SLOTS) ? SLOTS : np_reg;
      intr = '0;
      addc = '0;
      disp = '0;
      push_res(RK_CYCLE, '0, tick_cnt, 0);
      tick_cnt++;
      // finish requests, unmatched ones keep their order
      foreach (fin_q[i]) begin
        hit = 0;
        for (int s = 0; s < n && !hit; s++)
          if (busy[s] && stag[s] == fin_q[i]) begin
            push_res(RK_DONE, fin_q[i], (stime[s] == TIME_MAX) ? TIME_MAX : stime[s] + 1, 0);
            busy[s] = 0;
            stag[s] = '0;
            stime[s] = '0;
            hit = 1;
          end
        if (!hit) keep.push_back(fin_q[i]);
      end
      fin_q = keep;
      // time advance and preemption
      for (int s = 0; s < n; s++) begin
        if (stime[s] != TIME_MAX) stime[s]++;
        if (busy[s] && qnt_reg != 0 && stime[s] != 0 && stime[s] % qnt_reg == 0 &&
            run_tag_q.size() < RUN_D) begin
          run_tag_q.push_back(stag[s]);
          run_time_q.push_back(stime[s]);
          busy[s] = 0;
          stag[s] = '0;
          stime[s] = '0;
          intr++;
        end
      end
      while (wait_q.size() > 0 && run_tag_q.size() < RUN_D) begin
        run_tag_q.push_back(wait_q.pop_front());
        run_time_q.push_back('0);
        addc++;
      end
      for (int s = 0; s < n; s++)
        if (!busy[s] && run_tag_q.size() > 0) begin
          busy[s] = 1;
          stag[s] = run_tag_q.pop_front();
          stime[s] = run_time_q.pop_front();
          disp++;
        end
      push_res(RK_INTR, '0, intr, 0);
      push_res(RK_ADDED, '0, addc, 0);
      push_res(RK_DISP, '0, disp, 1);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d tag %h value %h last %b",
                   got.rkind, got.tag, got.val, got.lst);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d tag %h value %h last %b, got kind %0d tag %h value %h last %b",
                   want.rkind, want.tag, want.val, want.lst,
                   got.rkind, got.tag, got.val, got.lst);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] kind;
  logic [TAG_W-1:0] task_tag;
  logic out_valid, out_ready;
  logic [2:0] result_kind;
  logic [TAG_W-1:0] task_tag_res;
  logic [TIME_W-1:0] value;
  logic last;
  logic cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sched_scoreboard sb;
  bit quiet_phase;     // no idling on either side
  bit hold_sink;       // request a long output stall
  int idle_cycles;

  multiprocessor_round_robin_scheduler u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .task_tag(task_tag),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .task_tag_res(task_tag_res), .value(value), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // input acceptance feeds the predictor, output acceptance is checked
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(kind, task_tag);
      if (out_valid && out_ready)
        sb.check_result('{result_kind, task_tag_res, value, last});
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random ready bursts, plus a long hold when requested
  initial begin
    int n;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [1:0] k, logic [TAG_W-1:0] t);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    task_tag <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // lower valid and wait until every expected result has been seen
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    // a new task or finish item gives no result, let the block settle
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 0;
  endtask

  // tags drawn from a small pool so finish requests find their tasks
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 9) == 0) return TAG_W'($urandom());
    return TAG_W'($urandom_range(0, 15));
  endfunction

  task automatic random_run(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_item(KIND_NEW, pick_tag());
      else if (r < 60) send_item(KIND_FIN, pick_tag());
      else if (r < 97) send_item(KIND_TICK, TAG_W'($urandom()));
      else send_item(2'd3, TAG_W'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    quiet_phase = 0;
    hold_sink = 0;
    rst = 1;
    in_valid = 0;
    kind = KIND_NEW;
    task_tag = '0;
    cfg_we = 0;
    cfg_index = CFG_NUM_PROC;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset config, edge tags, unused kind, tick on empty
    send_item(KIND_TICK, 16'hffff);
    send_item(KIND_NEW, 16'h0000);
    send_item(KIND_NEW, 16'hffff);
    send_item(KIND_NEW, 16'h5555);
    send_item(2'd3, 16'haaaa);
    send_item(KIND_FIN, 16'h1234);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_FIN, 16'h0000);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_FIN, 16'hffff);
    send_item(KIND_FIN, 16'hffff);
    send_item(KIND_TICK, 16'h0000);
    drain();

    // zero slot count acts as one, zero quantum never preempts
    write_cfg(CFG_NUM_PROC, 16'd0);
    write_cfg(CFG_QUANTUM, 16'd0);
    send_item(KIND_NEW, 16'h00aa);
    send_item(KIND_NEW, 16'h00bb);
    for (int i = 0; i < 4; i++) send_item(KIND_TICK, '0);
    drain();

    // fill the finish list past its depth and the wait fifo past its depth
    for (int i = 0; i < FIN_D + 2; i++) send_item(KIND_FIN, TAG_W'(16'h8000 + i));
    for (int i = 0; i < WAIT_D + 2; i++) send_item(KIND_NEW, TAG_W'(16'h4000 + i));
    send_item(KIND_TICK, '0);
    drain();

    // oversize slot count, quantum one, long output stall under load
    write_cfg(CFG_NUM_PROC, 16'd15);
    write_cfg(CFG_QUANTUM, 16'd1);
    hold_sink = 1;
    random_run(25);
    drain();

    // full slot count, large quantum
    write_cfg(CFG_NUM_PROC, 16'd8);
    write_cfg(CFG_QUANTUM, 16'hffff);
    random_run(30);
    drain();

    write_cfg(CFG_NUM_PROC, 16'd3);
    write_cfg(CFG_QUANTUM, 16'd2);
    random_run(35);
    drain();

    // last part without idling
    quiet_phase = 1;
    write_cfg(CFG_NUM_PROC, 16'd5);
    write_cfg(CFG_QUANTUM, 16'd3);
    random_run(26);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mrrs_pkg.sv
rtl/core/mrrs_ram.sv
rtl/core/multiprocessor_round_robin_scheduler.sv
rtl/core/mrrs_checker.sv
verif/testbench.sv
